### hdl/rbb_pkg.sv
// Shared constants, register codes and controller/datapath interface types.
`default_nettype none
package rbb_pkg;
    localparam int MaxWidth   = 1024;
    localparam int MaxHeight  = 1024;
    localparam int MaxRadius  = 7;
    localparam int RingRows   = 2 * MaxRadius + 2;
    localparam int ColBits    = $clog2(MaxWidth);
    localparam int RowBits    = $clog2(MaxHeight);
    localparam int RingBits   = $clog2(RingRows);
    localparam int AddrBits   = RingBits + ColBits;
    localparam int SumBits    = 16;
    localparam int CountBits  = 8;
    localparam int DivCntBits = $clog2(SumBits);

    localparam logic [1:0] RegWidth  = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;
    localparam logic [1:0] RegRadius = 2'd2;

    localparam logic CmdPush  = 1'b0;
    localparam logic CmdDrain = 1'b1;

    typedef struct packed {
        logic accept;
        logic check;
        logic sum_step;
        logic div_start;
        logic div_step;
        logic emit_done;
    } cmd_t;

    typedef struct packed {
        logic ready_hit;
        logic sum_last;
        logic div_last;
    } stat_t;
endpackage
`default_nettype wire

### hdl/rbb_ctrl.sv
// Sequencer for one item: check, window sum, divide, hand off result.
`default_nettype none
module rbb_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  rbb_pkg::stat_t     stat,
    output rbb_pkg::cmd_t      cmd
);
    typedef enum logic [2:0] {IDLE, CHECK, RD, ACC, DIV, OUT} state_t;
    state_t state_reg, state_next;

    // pick next state and commands
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = CHECK;
                end
            end
            CHECK: begin
                cmd.check = 1'b1;
                state_next = stat.ready_hit ? RD : IDLE;
            end
            RD: state_next = ACC;
            ACC: begin
                cmd.sum_step = 1'b1;
                if (stat.sum_last) begin
                    cmd.div_start = 1'b1;
                    state_next = DIV;
                end else begin
                    state_next = RD;
                end
            end
            DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) state_next = OUT;
            end
            OUT: begin
                if (m_ready) begin
                    cmd.emit_done = 1'b1;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = (state_reg == OUT);

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= IDLE;
        else state_reg <= state_next;
    end
endmodule
`default_nettype wire

### hdl/rbb_datapath.sv
// Positions, line store, window accumulators and shared divider.
`default_nettype none
module rbb_datapath (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        restart,
    input  wire logic [10:0] w_eff,
    input  wire logic [10:0] h_eff,
    input  wire logic [2:0]  r,
    input  rbb_pkg::cmd_t    cmd,
    output rbb_pkg::stat_t   stat,
    input  wire logic        command,
    input  wire logic [7:0]  red_in,
    input  wire logic [7:0]  green_in,
    input  wire logic [7:0]  blue_in,
    output logic [7:0]       red_out,
    output logic [7:0]       green_out,
    output logic [7:0]       blue_out,
    output logic [9:0]       column,
    output logic [9:0]       row,
    output logic             frame_last
);
    localparam int CB = rbb_pkg::ColBits;
    localparam int RB = rbb_pkg::RowBits;
    localparam int SB = rbb_pkg::SumBits;
    localparam int NB = rbb_pkg::CountBits;

    logic [23:0] mem [rbb_pkg::RingRows * rbb_pkg::MaxWidth];
    logic [23:0] rd_data_reg;

    logic [CB:0] in_col_reg;
    logic [RB:0] in_row_reg;
    logic [CB-1:0] out_col_reg, x_reg, x0_reg, x1_reg;
    logic [RB-1:0] out_row_reg, y_reg, y1_reg;
    logic done_reg;
    logic [SB-1:0] sum_reg [3];
    logic [NB:0] rem_reg [3];
    logic [NB-1:0] count_reg;
    logic [rbb_pkg::DivCntBits-1:0] div_cnt_reg;

    logic [CB:0] need_x, col_inc;
    logic [RB:0] need_y, row_inc;
    logic [CB-1:0] x0;
    logic [RB-1:0] y0;
    logic push, last;

    // window bounds and readiness
    always_comb begin
        need_x = {1'b0, out_col_reg} + {{(CB-2){1'b0}}, r};
        if (need_x > w_eff - 11'd1) need_x = w_eff - 11'd1;
        need_y = {1'b0, out_row_reg} + {{(RB-2){1'b0}}, r};
        if (need_y > h_eff - 11'd1) need_y = h_eff - 11'd1;
        x0 = (out_col_reg > {{(CB-3){1'b0}}, r}) ?
             out_col_reg - {{(CB-3){1'b0}}, r} : '0;
        y0 = (out_row_reg > {{(RB-3){1'b0}}, r}) ?
             out_row_reg - {{(RB-3){1'b0}}, r} : '0;
        stat.ready_hit = done_reg || (in_row_reg > need_y) ||
                         (in_row_reg == need_y && in_col_reg > need_x);
        stat.sum_last = (x_reg == x1_reg) && (y_reg == y1_reg);
        stat.div_last = (div_cnt_reg == '1);
        push = cmd.accept && (command == rbb_pkg::CmdPush) && !done_reg;
        col_inc = in_col_reg + 11'd1;
        row_inc = in_row_reg + 11'd1;
        last = ({1'b0, out_col_reg} + 11'd1 >= w_eff) &&
               ({1'b0, out_row_reg} + 11'd1 >= h_eff);
    end

    // write pushed pixels, read window pixels
    always_ff @(posedge aclk) begin
        if (push)
            mem[{in_row_reg[rbb_pkg::RingBits-1:0], in_col_reg[CB-1:0]}] <=
                {blue_in, green_in, red_in};
        rd_data_reg <= mem[{y_reg[rbb_pkg::RingBits-1:0], x_reg}];
    end

    // advance frame positions
    always_ff @(posedge aclk) begin
        if (!aresetn || restart || (cmd.emit_done && last)) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            done_reg    <= 1'b0;
        end else begin
            if (push) begin
                if (col_inc >= w_eff) begin
                    in_col_reg <= '0;
                    in_row_reg <= row_inc;
                    if (row_inc >= h_eff) done_reg <= 1'b1;
                end else begin
                    in_col_reg <= col_inc;
                end
            end
            if (cmd.emit_done) begin
                if ({1'b0, out_col_reg} + 11'd1 >= w_eff) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 10'd1;
                end else begin
                    out_col_reg <= out_col_reg + 10'd1;
                end
            end
        end
    end

    // sweep window, accumulate, then divide
    always_ff @(posedge aclk) begin
        logic [NB:0] t;
        if (cmd.check) begin
            x_reg  <= x0;
            y_reg  <= y0;
            x0_reg <= x0;
            x1_reg <= need_x[CB-1:0];
            y1_reg <= need_y[RB-1:0];
            count_reg <= '0;
            for (int c = 0; c < 3; c++) sum_reg[c] <= '0;
        end
        if (cmd.sum_step) begin
            count_reg <= count_reg + 8'd1;
            for (int c = 0; c < 3; c++)
                sum_reg[c] <= sum_reg[c] + {8'd0, rd_data_reg[8*c +: 8]};
            if (x_reg == x1_reg) begin
                x_reg <= x0_reg;
                y_reg <= y_reg + 10'd1;
            end else begin
                x_reg <= x_reg + 10'd1;
            end
        end
        if (cmd.div_start) begin
            div_cnt_reg <= '0;
            for (int c = 0; c < 3; c++) rem_reg[c] <= '0;
        end
        if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + 4'd1;
            for (int c = 0; c < 3; c++) begin
                t = {rem_reg[c][NB-1:0], sum_reg[c][SB-1]};
                if (t >= {1'b0, count_reg}) begin
                    rem_reg[c] <= t - {1'b0, count_reg};
                    sum_reg[c] <= {sum_reg[c][SB-2:0], 1'b1};
                end else begin
                    rem_reg[c] <= t;
                    sum_reg[c] <= {sum_reg[c][SB-2:0], 1'b0};
                end
            end
        end
    end

    assign red_out    = sum_reg[0][7:0];
    assign green_out  = sum_reg[1][7:0];
    assign blue_out   = sum_reg[2][7:0];
    assign column     = out_col_reg;
    assign row        = out_row_reg;
    assign frame_last = last;
endmodule
`default_nettype wire

### hdl/rgb_box_blur_clipped.sv
// Top level: configuration registers, controller and datapath.
// RGB box blur over a clipped (2r+1)x(2r+1) window.
// Input channel s_*: one item per pixel in raster order (s_command push),
// or a drain tick (s_command drain) that only lets pending results out.
// Result channel m_*: per-channel truncated mean with column, row and
// frame_last, in raster order, at most one result per input item.
// Each item is checked for readiness (CHECK); when a result is due, each
// window pixel is read and added (RD, ACC: one line-store read port,
// registered data), the sums pass the restoring divider (DIV) and the
// result is output (OUT). A clipped window holds N pixels, N up to 225.
// Items are handled one at a time; s_ready is high only between items.
// While m_ready is low the result holds and no new item is accepted.
// Reset (aresetn low, synchronous) restores width 1024, height 1024,
// radius 5 and clears all frame positions; the line store is not cleared.
// A write to the width, height or radius register restarts the frame.
`default_nettype none
module rgb_box_blur_clipped (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [7:0]  s_red_in,
    input  wire logic [7:0]  s_green_in,
    input  wire logic [7:0]  s_blue_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_red_out,
    output logic [7:0]       m_green_out,
    output logic [7:0]       m_blue_out,
    output logic [9:0]       m_column,
    output logic [9:0]       m_row,
    output logic             m_frame_last
);
    logic [10:0] width_reg, height_reg, w_eff, h_eff;
    logic [2:0]  radius_reg;
    logic        wr, hit;
    rbb_pkg::cmd_t  cmd;
    rbb_pkg::stat_t stat;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    // decode register writes
    always_comb begin
        hit = 1'b0;
        unique case (paddr[3:2])
            rbb_pkg::RegWidth, rbb_pkg::RegHeight, rbb_pkg::RegRadius: hit = wr;
            default: hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd1024;
            height_reg <= 11'd1024;
            radius_reg <= 3'd5;
        end else if (wr) begin
            unique case (paddr[3:2])
                rbb_pkg::RegWidth:  width_reg  <= pwdata[10:0];
                rbb_pkg::RegHeight: height_reg <= pwdata[10:0];
                rbb_pkg::RegRadius: radius_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // read back registers
    always_comb begin
        unique case (paddr[3:2])
            rbb_pkg::RegWidth:  prdata = {21'd0, width_reg};
            rbb_pkg::RegHeight: prdata = {21'd0, height_reg};
            rbb_pkg::RegRadius: prdata = {29'd0, radius_reg};
            default:            prdata = '0;
        endcase
    end

    // clamp frame size
    assign w_eff = (width_reg == '0) ? 11'd1 :
                   (width_reg > 11'(rbb_pkg::MaxWidth)) ? 11'(rbb_pkg::MaxWidth)
                                                         : width_reg;
    assign h_eff = (height_reg == '0) ? 11'd1 :
                   (height_reg > 11'(rbb_pkg::MaxHeight)) ? 11'(rbb_pkg::MaxHeight)
                                                           : height_reg;

    rbb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rbb_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (hit),
        .w_eff      (w_eff),
        .h_eff      (h_eff),
        .r          (radius_reg),
        .cmd        (cmd),
        .stat       (stat),
        .command    (s_command),
        .red_in     (s_red_in),
        .green_in   (s_green_in),
        .blue_in    (s_blue_in),
        .red_out    (m_red_out),
        .green_out  (m_green_out),
        .blue_out   (m_blue_out),
        .column     (m_column),
        .row        (m_row),
        .frame_last (m_frame_last)
    );
endmodule
`default_nettype wire
